// File: src/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C master transaction engine: item and
// result beats, engine state, phase, stage, operation, kind and status codes.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_WBYTE = 2'd2;

    localparam logic [1:0] KIND_REG_WRITE = 2'd0;
    localparam logic [1:0] KIND_REG_READ  = 2'd1;
    localparam logic [1:0] KIND_RAW_WRITE = 2'd2;
    localparam logic [1:0] KIND_RAW_READ  = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_ACK  = 2'd1;
    localparam logic [1:0] STATUS_ZERO_RD = 2'd2;

    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_START_A   = 5'd1;
    localparam logic [4:0] PH_START_B   = 5'd2;
    localparam logic [4:0] PH_TX_LOW    = 5'd3;
    localparam logic [4:0] PH_TX_HIGH   = 5'd4;
    localparam logic [4:0] PH_ACK_LOW   = 5'd5;
    localparam logic [4:0] PH_ACK_HIGH  = 5'd6;
    localparam logic [4:0] PH_LOAD      = 5'd7;
    localparam logic [4:0] PH_RS_PREP   = 5'd8;
    localparam logic [4:0] PH_RX_LOW    = 5'd9;
    localparam logic [4:0] PH_RX_HIGH   = 5'd10;
    localparam logic [4:0] PH_MACK_LOW  = 5'd11;
    localparam logic [4:0] PH_MACK_HIGH = 5'd12;
    localparam logic [4:0] PH_STOP_A    = 5'd13;
    localparam logic [4:0] PH_STOP_B    = 5'd14;
    localparam logic [4:0] PH_STOP_C    = 5'd15;

    localparam logic [1:0] STG_ADDR_W = 2'd0;
    localparam logic [1:0] STG_REG    = 2'd1;
    localparam logic [1:0] STG_DATA   = 2'd2;
    localparam logic [1:0] STG_ADDR_R = 2'd3;

    localparam logic [7:0] ACK_LIMIT_RESET = 8'd250;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] kind;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] length;
        logic [7:0] write_byte;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       need_data;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic [4:0] phase;
        logic [3:0] bit_count;
        logic [7:0] shift_reg;
        logic [7:0] bytes_left;
        logic [7:0] ack_wait_count;
        logic [1:0] txn_kind;
        logic [6:0] target_addr;
        logic [7:0] target_reg;
        logic [7:0] pending_byte;
        logic       pending_valid;
        logic       scl_level;
        logic       sda_level;
        logic [1:0] stage;
        logic       fail;
    } engine_t;

endpackage

// File: src/i2c_master_transaction_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_transaction_engine
// I2C master sequencer stepped one bus interval per tick beat, with register
// and raw read/write transactions, ACK polling and a single closing STOP.
//
//  channel | direction | handshake          | payload
//  cmd     | in        | cmd_valid/cmd_stall| i2cm_pkg::item_t
//  res     | out       | res_valid/res_stall| i2cm_pkg::result_t
//  cfg     | in        | cfg_valid/cfg_ready| ack_poll_limit, 8 bits
//
// One item per cycle while cmd_stall is low. Combinational step logic lies between
// the engine state register and the result register, backed by a one-beat skid
// stage that catches a result beat while res_stall holds the output.
// Reset: phase idle, bus released, ack_poll_limit 250, no beat held.
// cmd_stall is high only while the skid stage holds a beat.
// ----------------------------------------------------------------------------
module i2c_master_transaction_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  i2cm_pkg::item_t   cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output i2cm_pkg::result_t res,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);
    import i2cm_pkg::*;

    engine_t    eng_reg;
    engine_t    eng_next;
    result_t    step_res;
    result_t    res_reg;
    result_t    skid_reg;
    logic       res_valid_reg;
    logic       skid_valid_reg;
    logic [7:0] limit_reg;
    logic       accept;
    logic       take;

    i2cm_step u_step (
        .cur            (eng_reg),
        .item           (cmd),
        .ack_poll_limit (limit_reg),
        .nxt            (eng_next),
        .res            (step_res)
    );

    assign cmd_stall = skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign accept    = cmd_valid && !skid_valid_reg;
    assign take      = res_valid_reg && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg        <= '{phase:          PH_IDLE,
                                bit_count:      4'd0,
                                shift_reg:      8'd0,
                                bytes_left:     8'd0,
                                ack_wait_count: 8'd0,
                                txn_kind:       2'd0,
                                target_addr:    7'd0,
                                target_reg:     8'd0,
                                pending_byte:   8'd0,
                                pending_valid:  1'b0,
                                scl_level:      1'b1,
                                sda_level:      1'b1,
                                stage:          STG_ADDR_W,
                                fail:           1'b0};
            limit_reg      <= ACK_LIMIT_RESET;
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (accept)
            begin
                eng_reg <= eng_next;
            end
            if (take || !res_valid_reg)
            begin
                if (skid_valid_reg)
                begin
                    res_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
                else if (accept)
                begin
                    res_reg       <= step_res;
                    res_valid_reg <= 1'b1;
                end
                else
                begin
                    res_valid_reg <= 1'b0;
                end
            end
            else if (accept)
            begin
                skid_reg       <= step_res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> res_valid_reg)
        else $error("skid beat held without an output beat");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.done_res) |-> !res_reg.busy_res)
        else $error("done reported while still busy");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.read_valid) |-> res_reg.busy_res)
        else $error("read byte reported outside a transaction");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status != STATUS_OK) |-> res_reg.done_res)
        else $error("error status without done");

endmodule

// File: src/i2cm_step.sv
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state and result logic for one item: advances the bus sequencer by
// one tick, starts a transaction when idle, or latches a write byte.
// ----------------------------------------------------------------------------
module i2cm_step (
    input  i2cm_pkg::engine_t cur,
    input  i2cm_pkg::item_t   item,
    input  logic [7:0]        ack_poll_limit,
    output i2cm_pkg::engine_t nxt,
    output i2cm_pkg::result_t res
);
    import i2cm_pkg::*;

    logic [7:0] bl_dec;
    logic [3:0] bit_inc;
    logic       rv;
    logic       done;
    logic [1:0] st;

    assign bl_dec  = cur.bytes_left - 8'd1;
    assign bit_inc = cur.bit_count + 4'd1;

    always_comb
    begin
        nxt  = cur;
        rv   = 1'b0;
        done = 1'b0;
        st   = STATUS_OK;

        case (item.operation)
            OP_TICK:
            begin
                case (cur.phase)
                    PH_IDLE:
                    begin
                        nxt.scl_level = 1'b1;
                        nxt.sda_level = 1'b1;
                    end
                    PH_START_A:
                    begin
                        nxt.scl_level = 1'b1;
                        nxt.sda_level = 1'b1;
                        nxt.phase     = PH_START_B;
                    end
                    PH_START_B:
                    begin
                        nxt.scl_level = 1'b1;
                        nxt.sda_level = 1'b0;
                        nxt.bit_count = 4'd0;
                        nxt.phase     = PH_TX_LOW;
                    end
                    PH_TX_LOW:
                    begin
                        nxt.scl_level = 1'b0;
                        nxt.sda_level = cur.shift_reg[7];
                        nxt.phase     = PH_TX_HIGH;
                    end
                    PH_TX_HIGH:
                    begin
                        nxt.scl_level = 1'b1;
                        nxt.sda_level = cur.shift_reg[7];
                        nxt.shift_reg = {cur.shift_reg[6:0], 1'b0};
                        nxt.bit_count = bit_inc;
                        nxt.phase     = (bit_inc >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
                    end
                    PH_ACK_LOW:
                    begin
                        nxt.scl_level      = 1'b0;
                        nxt.sda_level      = 1'b1;
                        nxt.ack_wait_count = 8'd0;
                        nxt.phase          = PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH:
                    begin
                        nxt.scl_level = 1'b1;
                        nxt.sda_level = 1'b1;
                        if (!item.sda_in)
                        begin
                            case (cur.stage)
                                STG_ADDR_W:
                                begin
                                    if (cur.txn_kind == KIND_REG_WRITE
                                        || cur.txn_kind == KIND_REG_READ)
                                    begin
                                        nxt.shift_reg = cur.target_reg;
                                        nxt.stage     = STG_REG;
                                        nxt.bit_count = 4'd0;
                                        nxt.phase     = PH_TX_LOW;
                                    end
                                    else
                                    begin
                                        nxt.stage = STG_DATA;
                                        nxt.phase = (cur.bytes_left == 8'd0)
                                                    ? PH_STOP_A : PH_LOAD;
                                    end
                                end
                                STG_REG:
                                begin
                                    if (cur.txn_kind == KIND_REG_READ)
                                    begin
                                        nxt.shift_reg = {cur.target_addr, 1'b1};
                                        nxt.stage     = STG_ADDR_R;
                                        nxt.phase     = PH_RS_PREP;
                                    end
                                    else
                                    begin
                                        nxt.stage = STG_DATA;
                                        nxt.phase = (cur.bytes_left == 8'd0)
                                                    ? PH_STOP_A : PH_LOAD;
                                    end
                                end
                                STG_DATA:
                                begin
                                    nxt.bytes_left = bl_dec;
                                    nxt.phase = (bl_dec == 8'd0) ? PH_STOP_A : PH_LOAD;
                                end
                                default:
                                begin
                                    if (cur.bytes_left == 8'd0)
                                    begin
                                        nxt.phase = PH_STOP_A;
                                    end
                                    else
                                    begin
                                        nxt.bit_count = 4'd0;
                                        nxt.phase     = PH_RX_LOW;
                                    end
                                end
                            endcase
                        end
                        else if (cur.ack_wait_count >= ack_poll_limit)
                        begin
                            nxt.fail  = 1'b1;
                            nxt.phase = PH_STOP_A;
                        end
                        else
                        begin
                            nxt.ack_wait_count = cur.ack_wait_count + 8'd1;
                        end
                    end
                    PH_LOAD:
                    begin
                        nxt.scl_level = 1'b0;
                        nxt.sda_level = 1'b1;
                        if (cur.pending_valid)
                        begin
                            nxt.shift_reg     = cur.pending_byte;
                            nxt.pending_valid = 1'b0;
                            nxt.bit_count     = 4'd0;
                            nxt.phase         = PH_TX_LOW;
                        end
                    end
                    PH_RS_PREP:
                    begin
                        nxt.scl_level = 1'b0;
                        nxt.sda_level = 1'b1;
                        nxt.phase     = PH_START_A;
                    end
                    PH_RX_LOW:
                    begin
                        nxt.scl_level = 1'b0;
                        nxt.sda_level = 1'b1;
                        nxt.phase     = PH_RX_HIGH;
                    end
                    PH_RX_HIGH:
                    begin
                        nxt.scl_level = 1'b1;
                        nxt.sda_level = 1'b1;
                        nxt.shift_reg = {cur.shift_reg[6:0], item.sda_in};
                        nxt.bit_count = bit_inc;
                        if (bit_inc >= 4'd8)
                        begin
                            rv        = 1'b1;
                            nxt.phase = PH_MACK_LOW;
                        end
                    end
                    PH_MACK_LOW:
                    begin
                        nxt.scl_level = 1'b0;
                        nxt.sda_level = (cur.bytes_left <= 8'd1);
                        nxt.phase     = PH_MACK_HIGH;
                    end
                    PH_MACK_HIGH:
                    begin
                        nxt.scl_level  = 1'b1;
                        nxt.sda_level  = (cur.bytes_left <= 8'd1);
                        nxt.bytes_left = bl_dec;
                        if (bl_dec == 8'd0)
                        begin
                            nxt.phase = PH_STOP_A;
                        end
                        else
                        begin
                            nxt.bit_count = 4'd0;
                            nxt.phase     = PH_RX_LOW;
                        end
                    end
                    PH_STOP_A:
                    begin
                        nxt.scl_level = 1'b0;
                        nxt.sda_level = 1'b0;
                        nxt.phase     = PH_STOP_B;
                    end
                    PH_STOP_B:
                    begin
                        nxt.scl_level = 1'b1;
                        nxt.sda_level = 1'b0;
                        nxt.phase     = PH_STOP_C;
                    end
                    PH_STOP_C:
                    begin
                        nxt.scl_level = 1'b1;
                        nxt.sda_level = 1'b1;
                        nxt.phase     = PH_IDLE;
                        done          = 1'b1;
                        st            = cur.fail ? STATUS_NO_ACK : STATUS_OK;
                        nxt.fail      = 1'b0;
                    end
                    default:
                    begin
                        nxt.scl_level = 1'b1;
                        nxt.sda_level = 1'b1;
                        nxt.phase     = PH_IDLE;
                        nxt.fail      = 1'b0;
                    end
                endcase
            end
            OP_START:
            begin
                if (cur.phase == PH_IDLE)
                begin
                    nxt.pending_valid = 1'b0;
                    if (item.kind == KIND_RAW_READ && item.length == 8'd0)
                    begin
                        done = 1'b1;
                        st   = STATUS_ZERO_RD;
                    end
                    else
                    begin
                        nxt.txn_kind       = item.kind;
                        nxt.target_addr    = item.device_address;
                        nxt.target_reg     = item.register_address;
                        nxt.bytes_left     = item.length;
                        nxt.fail           = 1'b0;
                        nxt.ack_wait_count = 8'd0;
                        nxt.bit_count      = 4'd0;
                        nxt.stage = (item.kind == KIND_RAW_READ) ? STG_ADDR_R : STG_ADDR_W;
                        nxt.shift_reg = {item.device_address, item.kind == KIND_RAW_READ};
                        nxt.phase = PH_START_A;
                    end
                end
            end
            OP_WBYTE:
            begin
                nxt.pending_byte  = item.write_byte;
                nxt.pending_valid = 1'b1;
            end
            default:
            begin
                nxt = cur;
            end
        endcase

        res.scl_out    = nxt.scl_level;
        res.sda_out    = nxt.sda_level;
        res.read_byte  = rv ? nxt.shift_reg : 8'd0;
        res.read_valid = rv;
        res.need_data  = (nxt.phase == PH_LOAD) && !nxt.pending_valid;
        res.busy_res   = (nxt.phase != PH_IDLE);
        res.done_res   = done;
        res.status     = st;
    end

endmodule
